@@ rtl/rau_pkg.sv @@
// Package for the rational arithmetic unit: opcodes, status codes and stream widths.
// No dependencies; used by rational_arithmetic_unit.
package rau_pkg;
	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 72;

	localparam logic [2:0] OP_NORM = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_EQ   = 3'd5;
	localparam logic [2:0] OP_LT   = 3'd6;
	localparam logic [2:0] OP_NOP  = 3'd7;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZDEN = 2'd1;
	localparam logic [1:0] STAT_DIV0 = 2'd2;
	localparam logic [1:0] STAT_OVF  = 2'd3;
endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: reduces one or two fractions, combines or compares them, reduces any result.
// Depends on rau_pkg (opcodes, status codes, stream widths).
//
// channel | dir | payload (lowest bits first)
// s_*     | in  | opcode[2:0] a_num[34:3] a_den[66:35] b_num[98:67] b_den[130:99], zero pad
// m_*     | out | res_num[31:0] res_den[62:32] compare_true[63] status[65:64], zero pad
//
// One item is worked at a time by a sequencer around subtract/compare logic for restoring
// division, a separate compare for binary GCD, and one shift-add multiplier.
// The run time of an item depends on the data: each reduction is a binary GCD followed
// by two restoring divisions (numerator, then denominator, by the GCD), and products
// come from the shift-add multiplier. A no-op or a zero denominator skips all of these.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next item is accepted meanwhile.
// arst_n clears control state only; the datapath registers need no reset.
module rational_arithmetic_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// opcode, a_num, a_den, b_num, b_den
	input  logic [rau_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// res_num, res_den, compare_true, status
	output logic [rau_pkg::M_TDATA_W-1:0] m_tdata
);
	import rau_pkg::*;

	localparam int W   = VALUE_WIDTH;
	localparam int PW  = 2 * VALUE_WIDTH;
	localparam int KW  = $clog2(PW);
	localparam int MCW = $clog2(VALUE_WIDTH);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RSTART = 4'd1;
	localparam logic [3:0] S_GEVEN  = 4'd2;
	localparam logic [3:0] S_GCD    = 4'd3;
	localparam logic [3:0] S_GSHIFT = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_POST   = 4'd6;
	localparam logic [3:0] S_MUL    = 4'd7;
	localparam logic [3:0] S_COMB   = 4'd8;
	localparam logic [3:0] S_CHECK  = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	localparam logic [1:0] RET_A = 2'd0;
	localparam logic [1:0] RET_B = 2'd1;
	localparam logic [1:0] RET_R = 2'd2;

	localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		mag_of = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	logic [3:0]    state_q;
	logic [1:0]    ret_q;
	logic [2:0]    op_q;
	logic [W-1:0]  bnr_q, bdr_q;            // raw b fields
	logic [W-1:0]  am_q, ad_q, bm_q, bd_q;  // reduced operands
	logic          an_q, bn_q;
	logic [PW-1:0] rm_q, rd_q;              // value under reduction
	logic          rneg_q;
	logic [PW-1:0] gx_q, gy_q;
	logic [KW-1:0] gk_q;
	logic [PW-1:0] dq_q, dr_q;
	logic [KW-1:0] dcnt_q;
	logic          dsel_q;
	logic [PW-1:0] acc_q, mcand_q;
	logic [W-1:0]  mplier_q;
	logic [MCW-1:0] mcnt_q;
	logic [1:0]    mi_q;
	logic [PW-1:0] pa_q, pb_q, pc_q;
	logic [31:0]   rnum_q;
	logic [30:0]   rden_q;
	logic          rcmp_q;
	logic [1:0]    rst_q;
	logic [M_TDATA_W-1:0] out_q;
	logic          out_valid_q;
	logic          out_load;

	// input fields, low VALUE_WIDTH bits
	logic [2:0]   in_op;
	logic [W-1:0] in_an, in_ad, in_bn, in_bd;
	assign in_op = s_tdata[2:0];
	assign in_an = s_tdata[3 +: W];
	assign in_ad = s_tdata[35 +: W];
	assign in_bn = s_tdata[67 +: W];
	assign in_bd = s_tdata[99 +: W];

	// subtract/compare logic for division, and a separate compare for GCD
	logic [PW:0]   div_t;
	logic          div_ge;
	logic [PW:0]   div_diff;
	logic          g_ge;
	assign div_t    = {dr_q, dq_q[PW-1]};
	assign div_ge   = div_t >= {1'b0, gy_q};
	assign div_diff = div_t - {1'b0, gy_q};
	assign g_ge     = gx_q >= gy_q;
	logic [PW-1:0] dq_next;
	assign dq_next  = {dq_q[PW-2:0], div_ge};

	// multiplier operand selection for the next product
	logic [1:0]   mi_sel;
	logic [W-1:0] mx, my;
	always_comb begin
		case (mi_sel)
			2'd0: begin
				mx = am_q;
				my = (op_q == OP_MUL) ? bm_q : bd_q;
			end
			2'd1: begin
				mx = bm_q;
				my = ad_q;
			end
			default: begin
				mx = ad_q;
				my = (op_q == OP_DIV) ? bm_q : bd_q;
			end
		endcase
	end

	logic [PW-1:0] acc_next;
	assign acc_next = mplier_q[0] ? acc_q + mcand_q : acc_q;

	// add/sub combine
	logic          nb;
	logic [PW-1:0] cmb_mag;
	logic          cmb_neg;
	always_comb begin
		nb = bn_q ^ (op_q != OP_ADD);
		if (an_q == nb) begin
			cmb_mag = pa_q + pb_q;
			cmb_neg = an_q;
		end else if (pa_q >= pb_q) begin
			cmb_mag = pa_q - pb_q;
			cmb_neg = an_q;
		end else begin
			cmb_mag = pb_q - pa_q;
			cmb_neg = nb;
		end
	end

	logic fits;
	assign fits = (rd_q <= LIM - PW'(1)) && (rneg_q ? (rm_q <= LIM) : (rm_q <= LIM - PW'(1)));
	logic [31:0] mag32;
	assign mag32 = 32'(rm_q);

	always_comb begin
		mi_sel = mi_q;
		if (state_q == S_POST)
			mi_sel = 2'd0;
		else if (state_q == S_MUL)
			mi_sel = mi_q + 2'd1;
	end

	// result moves into the output register once it is free or being drained
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q   <= in_op;
						bnr_q  <= in_bn;
						bdr_q  <= in_bd;
						rnum_q <= 32'd0;
						rden_q <= 31'd1;
						rcmp_q <= 1'b0;
						if (in_op == OP_NOP) begin
							rst_q   <= STAT_OK;
							state_q <= S_DONE;
						end else if (in_ad == '0 || (in_op != OP_NORM && in_bd == '0)) begin
							rst_q   <= STAT_ZDEN;
							state_q <= S_DONE;
						end else begin
							rst_q   <= STAT_OK;
							rm_q    <= PW'(mag_of(in_an));
							rd_q    <= PW'(mag_of(in_ad));
							rneg_q  <= in_an[W-1] ^ in_ad[W-1];
							ret_q   <= RET_A;
							state_q <= S_RSTART;
						end
					end
				end
				S_RSTART: begin
					gx_q <= rm_q;
					gy_q <= rd_q;
					gk_q <= '0;
					if (rm_q == '0) begin
						rd_q    <= PW'(1);
						rneg_q  <= 1'b0;
						state_q <= S_POST;
					end else begin
						state_q <= S_GEVEN;
					end
				end
				S_GEVEN: begin
					if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1;
						gy_q <= gy_q >> 1;
						gk_q <= gk_q + KW'(1);
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (gx_q == '0)
						state_q <= S_GSHIFT;
					else if (!gx_q[0])
						gx_q <= gx_q >> 1;
					else if (!gy_q[0])
						gy_q <= gy_q >> 1;
					else if (g_ge)
						gx_q <= gx_q - gy_q;
					else
						gy_q <= gy_q - gx_q;
				end
				S_GSHIFT: begin
					if (gk_q != '0) begin
						gy_q <= gy_q << 1;
						gk_q <= gk_q - KW'(1);
					end else begin
						dq_q    <= rm_q;
						dr_q    <= '0;
						dcnt_q  <= '0;
						dsel_q  <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == KW'(PW - 1)) begin
						dr_q   <= '0;
						dcnt_q <= '0;
						if (!dsel_q) begin
							rm_q   <= dq_next;
							dq_q   <= rd_q;
							dsel_q <= 1'b1;
						end else begin
							rd_q    <= dq_next;
							state_q <= S_POST;
						end
					end else begin
						dr_q   <= div_ge ? div_diff[PW-1:0] : div_t[PW-1:0];
						dq_q   <= dq_next;
						dcnt_q <= dcnt_q + KW'(1);
					end
				end
				S_POST: begin
					case (ret_q)
						RET_A: begin
							am_q <= rm_q[W-1:0];
							ad_q <= rd_q[W-1:0];
							an_q <= rneg_q;
							if (op_q == OP_NORM) begin
								state_q <= S_CHECK;
							end else begin
								rm_q    <= PW'(mag_of(bnr_q));
								rd_q    <= PW'(mag_of(bdr_q));
								rneg_q  <= bnr_q[W-1] ^ bdr_q[W-1];
								ret_q   <= RET_B;
								state_q <= S_RSTART;
							end
						end
						RET_B: begin
							bm_q <= rm_q[W-1:0];
							bd_q <= rd_q[W-1:0];
							bn_q <= rneg_q;
							if (op_q == OP_EQ) begin
								rcmp_q  <= (an_q == rneg_q) && (am_q == rm_q[W-1:0])
									&& (ad_q == rd_q[W-1:0]);
								state_q <= S_DONE;
							end else if (op_q == OP_DIV && rm_q == '0) begin
								rst_q   <= STAT_DIV0;
								state_q <= S_DONE;
							end else begin
								state_q <= S_MUL;
								mi_q    <= 2'd0;
								mcnt_q  <= '0;
								acc_q   <= '0;
								// operand b is not yet in bm_q/bd_q; pick from rm/rd
								case (op_q)
									OP_MUL: begin
										mcand_q  <= PW'(am_q);
										mplier_q <= rm_q[W-1:0];
									end
									default: begin
										mcand_q  <= PW'(am_q);
										mplier_q <= rd_q[W-1:0];
									end
								endcase
							end
						end
						default: state_q <= S_CHECK;
					endcase
				end
				S_MUL: begin
					if (mcnt_q == MCW'(W - 1)) begin
						case (mi_q)
							2'd0:    pa_q <= acc_next;
							2'd1:    pb_q <= acc_next;
							default: pc_q <= acc_next;
						endcase
						mcnt_q   <= '0;
						acc_q    <= '0;
						mcand_q  <= PW'(mx);
						mplier_q <= my;
						mi_q     <= mi_q + 2'd1;
						if (mi_q == 2'd2)
							state_q <= S_COMB;
					end else begin
						acc_q    <= acc_next;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						mcnt_q   <= mcnt_q + MCW'(1);
					end
				end
				S_COMB: begin
					ret_q <= RET_R;
					rd_q  <= pc_q;
					if (op_q == OP_MUL || op_q == OP_DIV) begin
						rm_q    <= pa_q;
						rneg_q  <= an_q ^ bn_q;
						state_q <= S_RSTART;
					end else if (op_q == OP_LT) begin
						rcmp_q  <= cmb_neg && (cmb_mag != '0);
						state_q <= S_DONE;
					end else begin
						rm_q    <= cmb_mag;
						rneg_q  <= cmb_neg;
						state_q <= S_RSTART;
					end
				end
				S_CHECK: begin
					if (fits) begin
						rnum_q <= rneg_q ? (32'd0 - mag32) : mag32;
						rden_q <= 31'(rd_q);
					end else begin
						rst_q <= STAT_OVF;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_q   <= {6'd0, rst_q, rcmp_q, rden_q, rnum_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_zden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65:64] == STAT_ZDEN |-> m_tdata[31:0] == 32'd0
			&& m_tdata[62:32] == 31'd1)
		else $error("zero-denominator result is not 0/1");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[62:32] != 31'd0)
		else $error("result denominator is zero");
	a_cmp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[63] |-> m_tdata[65:64] == STAT_OK)
		else $error("compare flag set with error status");
	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> gy_q != '0)
		else $error("division by zero gcd");
endmodule

@@ tb/rational_arithmetic_unit_tb.sv @@
// Self-checking testbench for rational_arithmetic_unit: directed and random fractions.
// Depends on rau_pkg and the RTL top level; holds its own rational predictor.
`timescale 1ns / 1ps

class rau_scoreboard;
	logic [71:0] pending_res[$];
	int          n_err;
	int          n_checked;

	function new();
		n_err = 0;
		n_checked = 0;
	endfunction

	// note an accepted item: store its predicted result
	function void note_item(logic [71:0] res);
		pending_res = {pending_res, res};
	endfunction

	function void check_result(logic [71:0] got);
		logic [71:0] exp_res;
		if (pending_res.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			n_err++;
			return;
		end
		exp_res = pending_res.pop_front();
		n_checked++;
		if (got[31:0] !== exp_res[31:0]) begin
			$display("%0t: res_num expected %h actual %h", $time, exp_res[31:0], got[31:0]);
			n_err++;
		end
		if (got[62:32] !== exp_res[62:32]) begin
			$display("%0t: res_den expected %h actual %h", $time, exp_res[62:32],
				got[62:32]);
			n_err++;
		end
		if (got[63] !== exp_res[63]) begin
			$display("%0t: compare_true expected %b actual %b", $time, exp_res[63], got[63]);
			n_err++;
		end
		if (got[65:64] !== exp_res[65:64]) begin
			$display("%0t: status expected %0d actual %0d", $time, exp_res[65:64],
				got[65:64]);
			n_err++;
		end
	endfunction
endclass

module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int VW = 32;

	typedef struct {
		logic         neg;
		logic [127:0] mag;
		logic [127:0] den;
	} frac_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	rau_scoreboard sb;
	int            n_items;
	int            n_ops[8];
	int            n_stat[4];

	rational_arithmetic_unit #(.VALUE_WIDTH(VW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// ---------------- predictor ----------------
	function automatic logic [127:0] gcd_of(logic [127:0] x, logic [127:0] y);
		logic [127:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_t reduce_frac(logic neg, logic [127:0] mag, logic [127:0] den);
		frac_t r;
		logic [127:0] g;
		g = gcd_of(mag, den);
		if (g == 0) g = 1;
		r.mag = mag / g;
		r.den = den / g;
		r.neg = (r.mag != 0) && neg;
		return r;
	endfunction

	// reduced sign/magnitude fraction from VW-bit two's complement fields
	function automatic frac_t load_operand(logic [31:0] rn, logic [31:0] rd);
		logic [127:0] nm, dm;
		logic [VW-1:0] tn, td;
		logic nn, dn;
		nn = rn[VW-1];
		dn = rd[VW-1];
		tn = rn[VW-1:0];
		td = rd[VW-1:0];
		if (nn) tn = ~tn + 1'b1;
		if (dn) td = ~td + 1'b1;
		nm = 128'(tn);
		dm = 128'(td);
		if (dm == 0) dm = 1;
		return reduce_frac(nn != dn, nm, dm);
	endfunction

	function automatic frac_t sum_frac(frac_t a, frac_t b, logic negate_b);
		logic [127:0] p1, p2, mag;
		logic nb, neg;
		p1 = a.mag * b.den;
		p2 = b.mag * a.den;
		nb = b.neg ^ negate_b;
		if (a.neg == nb) begin
			mag = p1 + p2; neg = a.neg;
		end else if (p1 >= p2) begin
			mag = p1 - p2; neg = a.neg;
		end else begin
			mag = p2 - p1; neg = nb;
		end
		return reduce_frac(neg, mag, a.den * b.den);
	endfunction

	function automatic logic [71:0] predict_result(logic [2:0] op, logic [31:0] an,
			logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
		logic [127:0] lim;
		logic [31:0]  num;
		logic [30:0]  den;
		logic         cmp, have;
		logic [1:0]   st;
		frac_t a, b, r, d;
		lim = 128'(1) << (VW - 1);
		num = 0; den = 1; cmp = 0; st = STAT_OK; have = 1;
		if (op == OP_NOP) begin
			have = 0;
		end else if (ad[VW-1:0] == 0 || (op != OP_NORM && bd[VW-1:0] == 0)) begin
			st = STAT_ZDEN; have = 0;
		end else begin
			a = load_operand(an, ad);
			b = load_operand(bn, bd);
			r = a;
			case (op)
				OP_ADD: r = sum_frac(a, b, 1'b0);
				OP_SUB: r = sum_frac(a, b, 1'b1);
				OP_MUL: r = reduce_frac(a.neg != b.neg, a.mag * b.mag, a.den * b.den);
				OP_DIV: begin
					if (b.mag == 0) begin
						st = STAT_DIV0; have = 0;
					end else begin
						r = reduce_frac(a.neg != b.neg, a.mag * b.den, a.den * b.mag);
					end
				end
				OP_EQ: begin
					cmp = (a.neg == b.neg && a.mag == b.mag && a.den == b.den);
					have = 0;
				end
				OP_LT: begin
					d = sum_frac(a, b, 1'b1);
					cmp = d.neg && d.mag != 0;
					have = 0;
				end
				default: ;
			endcase
			if (have) begin
				if (r.den > lim - 1 || (r.neg ? r.mag > lim : r.mag > lim - 1)) begin
					st = STAT_OVF;
				end else begin
					num = r.neg ? 32'(-r.mag) : 32'(r.mag);
					den = 31'(r.den);
				end
			end
		end
		return {6'd0, st, cmp, den, num};
	endfunction

	// ---------------- drivers ----------------
	task automatic send_item(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, bd, bn, ad, an, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(predict_result(op, an, ad, bn, bd));
		n_items++;
		n_ops[op]++;
	endtask

	// edge or random value for an operand field
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 6)) - 3);
			3: return 32'hffff_ffff;
			4: return 32'($urandom_range(1, 1000)) * (($urandom & 1) ? -1 : 1);
			5: return 32'($urandom_range(1, 60)) << $urandom_range(0, 24);
			6: return 32'($urandom_range(0, 65535)) - 32768;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_den();
		if ($urandom_range(0, 40) == 0) return 32'd0;
		return pick_value();
	endfunction

	// receiver: random stalls on m_tready, check each accepted result
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_result(m_tdata);
			n_stat[m_tdata[65:64]]++;
		end
	end

	// watchdog: allows for ~1900 items plus stalls, several times over
	initial begin
		#(4ns * 20_000_000);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int w;
		sb = new();
		n_items = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every opcode plus the named corner cases
		send_item(OP_NORM, 32'd6, -32'sd4, 32'd0, 32'd0);
		send_item(OP_NORM, 32'd1, 32'h8000_0000, 32'd1, 32'd1);   // den -2^31 overflows
		send_item(OP_NORM, 32'h8000_0000, -32'sd1, 32'd1, 32'd1); // num +2^31 overflows
		send_item(OP_NORM, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
		send_item(OP_NORM, 32'd0, -32'sd7, 32'd1, 32'd1);         // zero result
		send_item(OP_NORM, 32'd5, 32'd0, 32'd1, 32'd1);           // zero denominator
		send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);            // b den zero
		send_item(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);    // overflow
		send_item(OP_SUB, 32'd1, 32'd3, 32'd1, 32'd3);
		send_item(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
		send_item(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_item(OP_MUL, -32'sd2, 32'd3, 32'd3, -32'sd4);
		send_item(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5);            // division by zero
		send_item(OP_DIV, 32'd3, 32'd7, -32'sd5, 32'd11);
		send_item(OP_DIV, 32'd0, 32'd0, 32'd0, 32'd5);            // zero den wins
		send_item(OP_EQ, 32'd2, 32'd4, -32'sd3, -32'sd6);
		send_item(OP_EQ, 32'd2, 32'd4, 32'd3, -32'sd6);
		send_item(OP_LT, -32'sd1, 32'd3, 32'd1, 32'd3);
		send_item(OP_LT, 32'd1, 32'd3, 32'd1, 32'd3);
		send_item(OP_LT, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
		send_item(OP_NOP, $urandom, $urandom, $urandom, $urandom);
		send_item(OP_NOP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

		// drain once with the sender paused
		s_tvalid <= 1'b0;
		while (sb.pending_res.size() != 0) @(posedge clk);

		repeat (1900) begin
			send_item(3'($urandom_range(0, 7)), pick_value(), pick_den(),
				pick_value(), pick_den());
		end
		s_tvalid <= 1'b0;

		w = 0;
		while (sb.pending_res.size() != 0 && w < 100000) begin
			@(posedge clk);
			w++;
		end
		repeat (1500) @(posedge clk);

		$display("Covered %0d items over all opcodes, %0d results checked", n_items,
			sb.n_checked);
		$display("status: ok %0d zero-den %0d div0 %0d overflow %0d", n_stat[0],
			n_stat[1], n_stat[2], n_stat[3]);
		if (sb.n_err == 0 && sb.pending_res.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (sb.pending_res.size() != 0)
				$display("%0t: %0d results never arrived", $time, sb.pending_res.size());
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
